[design/bb3_pkg.sv]
package bb3_pkg;

    // Defaults for the top-level parameters
    localparam int BB3_MAX_WIDTH = 1024;
    localparam int BB3_RES_DEPTH = 8;     // result queue depth, power of two

    // Configuration register layout
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 13;
    localparam int CFG_DW      = 13;      // widest register

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd768;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_LIMIT = 13'd4096;

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    // Reciprocal multipliers: floor(y*K >> S) == floor(y/d) for y < 4096
    localparam logic [12:0] DIV3_MUL = 13'd5462;
    localparam logic [4:0]  DIV3_SH  = 5'd14;
    localparam logic [12:0] DIV9_MUL = 13'd7282;
    localparam logic [4:0]  DIV9_SH  = 5'd16;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Column sum of up to three pixels
    typedef struct packed {
        logic [9:0] red;
        logic [9:0] green;
        logic [9:0] blue;
    } t_csum;

    // Neighborhood sum of up to three columns
    typedef struct packed {
        logic [11:0] red;
        logic [11:0] green;
        logic [11:0] blue;
    } t_wsum;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       run_last;
        logic       image_last;
    } t_res;

    function automatic t_csum csum3(input t_rgb a, input t_rgb b, input t_rgb c);
        t_csum s;
        s.red   = 10'(a.red)   + 10'(b.red)   + 10'(c.red);
        s.green = 10'(a.green) + 10'(b.green) + 10'(c.green);
        s.blue  = 10'(a.blue)  + 10'(b.blue)  + 10'(c.blue);
        return s;
    endfunction

    function automatic t_wsum wsum3(input t_csum a, input t_csum b, input t_csum c);
        t_wsum s;
        s.red   = 12'(a.red)   + 12'(b.red)   + 12'(c.red);
        s.green = 12'(a.green) + 12'(b.green) + 12'(c.green);
        s.blue  = 12'(a.blue)  + 12'(b.blue)  + 12'(c.blue);
        return s;
    endfunction

    function automatic logic [3:0] box_n(input logic [1:0] rows, input logic [1:0] cols);
        return 4'(rows) * 4'(cols);
    endfunction

    // Mean rounded half up: (2s + n) / (2n), n in {1,2,3,4,6,9}
    function automatic logic [7:0] mean8(input logic [11:0] s, input logic [3:0] n);
        logic [12:0] x;
        logic [11:0] y;
        logic [12:0] k;
        logic [4:0]  sh;
        logic [24:0] p;
        x = {s, 1'b0} + 13'(n);
        case (n)
            4'd1: begin
                y = x[12:1]; k = 13'd1; sh = 5'd0;
            end
            4'd2: begin
                y = 12'(x >> 2); k = 13'd1; sh = 5'd0;
            end
            4'd4: begin
                y = 12'(x >> 3); k = 13'd1; sh = 5'd0;
            end
            4'd3: begin
                y = x[12:1]; k = DIV3_MUL; sh = DIV3_SH;
            end
            4'd6: begin
                y = 12'(x >> 2); k = DIV3_MUL; sh = DIV3_SH;
            end
            4'd9: begin
                y = x[12:1]; k = DIV9_MUL; sh = DIV9_SH;
            end
            default: begin
                y = '0; k = '0; sh = '0;
            end
        endcase
        p = 25'(y) * 25'(k);
        return 8'(p >> sh);
    endfunction

endpackage

[design/bb3_res_fifo.sv]
module bb3_res_fifo
    import bb3_pkg::*;
#(
    parameter int DEPTH = BB3_RES_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push0,
    input  t_res i_data0,
    input  logic i_push1,
    input  t_res i_data1,
    input  logic i_pop,
    output logic o_valid,
    output t_res o_data
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    t_res           r_buf [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CNW-1:0] r_count;
    logic [CNW-1:0] n_count;

    assign n_count = r_count + CNW'(i_push0) + CNW'(i_push1) - CNW'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(i_push0) + PW'(i_push1);
            r_rd    <= r_rd + PW'(i_pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_buf[r_wr] <= i_data0;
        end
        if (i_push1) begin
            r_buf[r_wr + PW'(1)] <= i_data1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd];

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push1 |-> i_push0)
        else $error("second slot pushed without first");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNW+1)'(r_count) + (CNW+1)'(i_push0) + (CNW+1)'(i_push1)
            <= (CNW+1)'(DEPTH) + (CNW+1)'(i_pop))
        else $error("result queue overflow");

endmodule

[design/box_blur_3x3_edge_averaged.sv]
// 3x3 edge-averaged box blur, RGB raster stream.
// One request per clock unless stalled; up to two results per row end, one per drain.
// A request's results pass the line-memory read, window update, neighborhood sum and
//   reciprocal divide in that order before they enter the result queue.
// Input stalls only while the result queue plus in-flight results exceed RES_DEPTH-2.
// Reset (sync, active low): clears positions and pipeline, width=1024, height=768.
//   The line memory is not cleared: an entry is always written before it is read.
module box_blur_3x3_edge_averaged
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = BB3_MAX_WIDTH,
    parameter int RES_DEPTH = BB3_RES_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    // input requests
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_op,
    input  logic [7:0]        i_in_red,
    input  logic [7:0]        i_in_green,
    input  logic [7:0]        i_in_blue,
    // results
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_red,
    output logic [7:0]        o_out_green,
    output logic [7:0]        o_out_blue,
    output logic              o_run_last,
    output logic              o_image_last
);

    localparam int AW = $clog2(MAX_WIDTH);        // column index
    localparam int CW = $clog2(MAX_WIDTH + 1);    // column count
    localparam int EW = (CW > WIDTH_BITS) ? CW : WIDTH_BITS;
    localparam int RW = $clog2(RES_DEPTH + 1);

    // Stage 1: line-memory read in flight
    typedef struct packed {
        logic          valid;
        logic          drain;
        logic          r_ge1;      // a row above exists
        logic          r_ge2;      // two rows above exist
        logic          c_ge1;
        logic          c_ge2;
        logic          emit_a;     // result for column c-1
        logic          emit_b;     // result for last column
        logic          preload;    // first pixel of last row seeds the drain window
        logic          h_ge2;
        logic          k_ge1;
        logic          k_right;
        logic          fin;
        logic          fwd;        // read hit the entry written by the previous request
        logic [AW-1:0] addr;
        t_rgb          pix;
    } t_s1;

    // Stage 2: window updated, sums formed
    typedef struct packed {
        logic valid;
        logic drain;
        logic r_ge2;
        logic c_ge1;
        logic c_ge2;
        logic emit_a;
        logic emit_b;
        logic h_ge2;
        logic k_ge1;
        logic k_right;
        logic fin;
    } t_s2;

    // Stage 3: one result slot awaiting division
    typedef struct packed {
        logic       valid;
        t_wsum      sum;
        logic [3:0] n;
        logic       run_last;
        logic       image_last;
    } t_slot;

    // ---------------------------------------------------------------
    // Configuration and effective image size
    // ---------------------------------------------------------------
    logic [WIDTH_BITS-1:0]  r_cfg_width;
    logic [HEIGHT_BITS-1:0] r_cfg_height;
    logic [CW-1:0]          eff_w;
    logic [HEIGHT_BITS-1:0] eff_h;
    logic [EW-1:0]          w_raw;

    assign w_raw = EW'(r_cfg_width);

    always_comb begin
        priority if (w_raw == '0) begin
            eff_w = CW'(1);
        end else if (w_raw > EW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(w_raw);
        end
        priority if (r_cfg_height == '0) begin
            eff_h = HEIGHT_BITS'(1);
        end else if (r_cfg_height > HEIGHT_LIMIT) begin
            eff_h = HEIGHT_LIMIT;
        end else begin
            eff_h = r_cfg_height;
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: accept, position tracking, memory read address
    // ---------------------------------------------------------------
    logic [HEIGHT_BITS-1:0] r_in_row;
    logic [AW-1:0]          r_in_col;
    logic [AW-1:0]          r_dcol;       // drain column
    logic [RW-1:0]          r_reserved;   // queued plus in-flight results
    logic [RW-1:0]          n_reserved;
    t_s1                    r_s1;
    t_s1                    n_s1;
    t_s2                    r_s2;
    t_slot                  r_s3_0;
    t_slot                  r_s3_1;
    t_slot                  n_s3_0;
    t_slot                  n_s3_1;

    logic          acc;
    logic          pop;
    logic          is_drain;
    logic          pix_ok;
    logic          drn_ok;
    logic [CW-1:0] col_p1;
    logic [CW-1:0] dcol_p1;
    logic          last_col;
    logic          d_fin;
    logic          row_ge1;
    logic          emit_a;
    logic          emit_b;
    logic [1:0]    cnt;
    logic [AW-1:0] rd_addr;

    assign acc      = i_in_valid && !o_in_stall;
    assign is_drain = (i_op == OP_DRAIN);
    assign col_p1   = CW'(r_in_col) + CW'(1);
    assign dcol_p1  = CW'(r_dcol) + CW'(1);
    assign last_col = (col_p1 == eff_w);
    assign d_fin    = (dcol_p1 == eff_w);
    assign row_ge1  = (r_in_row != '0);
    // pixels past the image and drains before the last row is complete are dropped
    assign pix_ok   = !is_drain && (r_in_row < eff_h);
    assign drn_ok   = is_drain && (r_in_row == eff_h);
    assign emit_a   = row_ge1 && (r_in_col != '0);
    assign emit_b   = row_ge1 && last_col;
    assign rd_addr  = is_drain ? AW'(dcol_p1) : r_in_col;

    always_comb begin
        cnt = 2'd0;
        if (pix_ok) begin
            cnt = 2'(emit_a) + 2'(emit_b);
        end else if (drn_ok) begin
            cnt = 2'd1;
        end
    end

    always_comb begin
        n_s1         = '0;
        n_s1.valid   = acc && (pix_ok || drn_ok);
        n_s1.drain   = is_drain;
        n_s1.r_ge1   = row_ge1;
        n_s1.r_ge2   = (r_in_row > HEIGHT_BITS'(1));
        n_s1.c_ge1   = (r_in_col != '0);
        n_s1.c_ge2   = (r_in_col > AW'(1));
        n_s1.emit_a  = emit_a;
        n_s1.emit_b  = emit_b;
        n_s1.preload = (r_in_row == eff_h - HEIGHT_BITS'(1)) && (r_in_col == '0);
        n_s1.h_ge2   = (eff_h > HEIGHT_BITS'(1));
        n_s1.k_ge1   = (r_dcol != '0);
        n_s1.k_right = !d_fin;
        n_s1.fin     = d_fin;
        // write of the request in stage 1 lands on the same edge as this read
        n_s1.fwd     = r_s1.valid && !r_s1.drain && (r_s1.addr == rd_addr);
        n_s1.addr    = rd_addr;
        n_s1.pix     = '{red: i_in_red, green: i_in_green, blue: i_in_blue};
    end

    assign pop        = o_out_valid && !i_out_stall;
    assign n_reserved = r_reserved + RW'(acc ? cnt : 2'd0) - RW'(pop);
    assign o_in_stall = (r_reserved > RW'(RES_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
            r_in_row     <= '0;
            r_in_col     <= '0;
            r_dcol       <= '0;
            r_reserved   <= '0;
            r_s1         <= '0;
            r_s2         <= '0;
            r_s3_0       <= '0;
            r_s3_1       <= '0;
        end else begin
            r_reserved <= n_reserved;
            r_s1       <= n_s1;
            r_s2       <= '{valid: r_s1.valid, drain: r_s1.drain, r_ge2: r_s1.r_ge2,
                            c_ge1: r_s1.c_ge1, c_ge2: r_s1.c_ge2, emit_a: r_s1.emit_a,
                            emit_b: r_s1.emit_b, h_ge2: r_s1.h_ge2, k_ge1: r_s1.k_ge1,
                            k_right: r_s1.k_right, fin: r_s1.fin};
            r_s3_0     <= n_s3_0;
            r_s3_1     <= n_s3_1;
            if (acc && pix_ok) begin
                if (last_col) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + HEIGHT_BITS'(1);
                end else begin
                    r_in_col <= AW'(col_p1);
                end
            end else if (acc && drn_ok) begin
                if (d_fin) begin
                    // image done: next pixel starts a new one
                    r_in_row <= '0;
                    r_in_col <= '0;
                    r_dcol   <= '0;
                end else begin
                    r_dcol <= AW'(dcol_p1);
                end
            end
            // a register write restarts the image
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[WIDTH_BITS-1:0];
                    CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[HEIGHT_BITS-1:0];
                endcase
                r_in_row <= '0;
                r_in_col <= '0;
                r_dcol   <= '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: line memory read-modify-write, column sums into windows
    // Memory entry = {row two above, row above} at one column.
    // ---------------------------------------------------------------
    logic [47:0] r_row_mem [MAX_WIDTH];
    logic [47:0] r_mem_q;
    logic [47:0] r_fwd_q;
    logic [47:0] mem_d;
    logic [47:0] wdata;
    logic        s1_wr;
    t_rgb        top;
    t_rgb        mid;
    t_csum       pcol;
    t_csum       dcol_sum;
    t_csum       seed_sum;
    t_csum       r_pw [3];   // pixel window: columns c-2, c-1, c
    t_csum       r_dw [3];   // drain window: columns k-1, k, k+1

    assign mem_d    = r_s1.fwd ? r_fwd_q : r_mem_q;
    assign top      = r_s1.r_ge2 ? t_rgb'(mem_d[47:24]) : t_rgb'('0);
    assign mid      = r_s1.r_ge1 ? t_rgb'(mem_d[23:0]) : t_rgb'('0);
    assign wdata    = {mid, r_s1.pix};
    assign s1_wr    = r_s1.valid && !r_s1.drain;
    assign pcol     = csum3(top, mid, r_s1.pix);
    assign seed_sum = csum3(t_rgb'('0), mid, r_s1.pix);
    assign dcol_sum = csum3(t_rgb'('0), t_rgb'(mem_d[47:24]), t_rgb'(mem_d[23:0]));

    always_ff @(posedge i_clk) begin
        r_mem_q <= r_row_mem[rd_addr];
        r_fwd_q <= wdata;
        if (s1_wr) begin
            r_row_mem[r_s1.addr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            r_pw[0] <= r_pw[1];
            r_pw[1] <= r_pw[2];
            r_pw[2] <= pcol;
            if (r_s1.preload) begin
                r_dw[2] <= seed_sum;
            end
        end
        if (r_s1.valid && r_s1.drain) begin
            r_dw[0] <= r_dw[1];
            r_dw[1] <= r_dw[2];
            r_dw[2] <= dcol_sum;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: neighborhood sums and counts, ordered into result slots
    // ---------------------------------------------------------------
    t_wsum      sum_a;
    t_wsum      sum_b;
    t_wsum      sum_d;
    logic [3:0] cnt_a;
    logic [3:0] cnt_b;
    logic [3:0] cnt_d;
    logic [1:0] rows_p;

    assign rows_p = r_s2.r_ge2 ? 2'd3 : 2'd2;
    assign sum_a  = wsum3(r_s2.c_ge2 ? r_pw[0] : t_csum'('0), r_pw[1], r_pw[2]);
    assign cnt_a  = box_n(rows_p, r_s2.c_ge2 ? 2'd3 : 2'd2);
    assign sum_b  = wsum3(t_csum'('0), r_s2.c_ge1 ? r_pw[1] : t_csum'('0), r_pw[2]);
    assign cnt_b  = box_n(rows_p, r_s2.c_ge1 ? 2'd2 : 2'd1);
    assign sum_d  = wsum3(r_s2.k_ge1 ? r_dw[0] : t_csum'('0), r_dw[1],
                          r_s2.k_right ? r_dw[2] : t_csum'('0));
    assign cnt_d  = box_n(r_s2.h_ge2 ? 2'd2 : 2'd1,
                          2'd1 + 2'(r_s2.k_ge1) + 2'(r_s2.k_right));

    always_comb begin
        n_s3_0 = '0;
        n_s3_1 = '0;
        if (r_s2.valid) begin
            if (r_s2.drain) begin
                n_s3_0 = '{valid: 1'b1, sum: sum_d, n: cnt_d,
                           run_last: 1'b1, image_last: r_s2.fin};
            end else if (r_s2.emit_a) begin
                n_s3_0 = '{valid: 1'b1, sum: sum_a, n: cnt_a,
                           run_last: !r_s2.emit_b, image_last: 1'b0};
                n_s3_1 = '{valid: r_s2.emit_b, sum: sum_b, n: cnt_b,
                           run_last: 1'b1, image_last: 1'b0};
            end else begin
                n_s3_0 = '{valid: r_s2.emit_b, sum: sum_b, n: cnt_b,
                           run_last: 1'b1, image_last: 1'b0};
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: rounded mean, then into the result queue
    // ---------------------------------------------------------------
    t_res res0;
    t_res res1;
    t_res q_data;

    assign res0 = '{red:   mean8(r_s3_0.sum.red,   r_s3_0.n),
                    green: mean8(r_s3_0.sum.green, r_s3_0.n),
                    blue:  mean8(r_s3_0.sum.blue,  r_s3_0.n),
                    run_last: r_s3_0.run_last, image_last: r_s3_0.image_last};
    assign res1 = '{red:   mean8(r_s3_1.sum.red,   r_s3_1.n),
                    green: mean8(r_s3_1.sum.green, r_s3_1.n),
                    blue:  mean8(r_s3_1.sum.blue,  r_s3_1.n),
                    run_last: r_s3_1.run_last, image_last: r_s3_1.image_last};

    bb3_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (r_s3_0.valid),
        .i_data0 (res0),
        .i_push1 (r_s3_1.valid),
        .i_data1 (res1),
        .i_pop   (pop),
        .o_valid (o_out_valid),
        .o_data  (q_data)
    );

    assign o_out_red    = q_data.red;
    assign o_out_green  = q_data.green;
    assign o_out_blue   = q_data.blue;
    assign o_run_last   = q_data.run_last;
    assign o_image_last = q_data.image_last;

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_in_col) < eff_w)
        else $error("column position past image width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row <= eff_h)
        else $error("row position past image height");

    a_reserve_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reserved <= RW'(RES_DEPTH))
        else $error("more results reserved than queue holds");

    a_image_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_image_last) |-> o_run_last)
        else $error("image end not flagged as last of its request");

endmodule
